// ===== src/tun_pkg.sv =====
// shared types, constants and helpers of the triangle unit normal block
package tun_pkg;

   localparam int CoordW    = 32;
   localparam int EdgeShift = 6;
   localparam int EdgeW     = CoordW - EdgeShift;
   localparam int MulW      = 28;
   localparam int ProdW     = 2 * MulW;
   localparam int CrossW    = 53;
   localparam int Mag2W     = 64;
   localparam int MagW      = 32;
   localparam int NormW     = 16;
   localparam int QuotW     = 15;
   localparam int LoW       = 27;
   localparam int StepW     = 5;
   localparam int CompW     = 2;
   localparam int RootTopBit = 62;

   localparam logic [QuotW-1:0] NormOne   = 15'h7FFF;
   localparam logic [StepW-1:0] CrossLast  = 5'd6;
   localparam logic [StepW-1:0] SquareLast = 5'd9;
   localparam logic [StepW-1:0] RootLast   = 5'd31;
   localparam logic [StepW-1:0] DivLast    = 5'd14;
   localparam logic [CompW-1:0] CompLast   = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CROSS,
      ST_SQUARE,
      ST_CHECK,
      ST_ROOT,
      ST_DIV_INIT,
      ST_DIV_STEP,
      ST_FINISH
   } state_type;

   typedef struct packed {
      state_type        state;
      logic [StepW-1:0] step;
      logic [CompW-1:0] comp;
      logic             busy;
      logic             load_out;
   } ctl_type;

   typedef struct packed {
      logic req_fire;
      logic mag2_zero;
      logic clamp;
      logic out_free;
   } sts_type;

   // wrapping difference, arithmetic shift right
   function automatic logic signed [EdgeW-1:0] edge_diff(input logic [CoordW-1:0] p,
                                                         input logic [CoordW-1:0] q);
      logic [CoordW-1:0] d;
      begin
         d = p - q;
         return d[CoordW-1:EdgeShift];
      end
   endfunction

endpackage

// ===== src/triangle_unit_normal_q15.sv =====
// top level: triangle unit normal in q15 with shared multiplier and compare-subtract
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   nine 32-bit signed vertex coordinates
//   rsp      out        rsp_valid/rsp_stall   three 16-bit signed normal components
//
// each item runs cross-product and square steps, a check, the root steps,
// then a divide per component and the hand-off; a clamped component skips its divide
// a zero magnitude skips root and divide and goes from the check to the hand-off
// req_stall is high from acceptance until the result moves to the output register
// a stalled result waits in the output register while the next item is taken
// synchronous reset clears the sequencer and the output valid
module triangle_unit_normal_q15 (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [tun_pkg::CoordW-1:0] req_vert_a_x,
   input  logic signed [tun_pkg::CoordW-1:0] req_vert_a_y,
   input  logic signed [tun_pkg::CoordW-1:0] req_vert_a_z,
   input  logic signed [tun_pkg::CoordW-1:0] req_vert_b_x,
   input  logic signed [tun_pkg::CoordW-1:0] req_vert_b_y,
   input  logic signed [tun_pkg::CoordW-1:0] req_vert_b_z,
   input  logic signed [tun_pkg::CoordW-1:0] req_vert_c_x,
   input  logic signed [tun_pkg::CoordW-1:0] req_vert_c_y,
   input  logic signed [tun_pkg::CoordW-1:0] req_vert_c_z,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [tun_pkg::NormW-1:0]  rsp_norm_x,
   output logic signed [tun_pkg::NormW-1:0]  rsp_norm_y,
   output logic signed [tun_pkg::NormW-1:0]  rsp_norm_z
);
   import tun_pkg::*;

   ctl_type ctl;
   sts_type sts;

   logic signed [EdgeW-1:0]  edge_ff [6];
   logic signed [EdgeW-1:0]  edge_in [6];
   logic signed [CrossW-1:0] cross_ff [3];
   logic signed [CrossW-1:0] cross_in [3];
   logic signed [NormW-1:0]  res_ff [3];
   logic signed [NormW-1:0]  res_in [3];
   logic [Mag2W-1:0]         mag2_ff, mag2_in;
   logic [Mag2W-1:0]         v_ff, v_in;
   logic [Mag2W-1:0]         r_ff, r_in;
   logic [Mag2W-1:0]         bit_ff, bit_in;
   logic [MagW-1:0]          rem_ff, rem_in;
   logic [QuotW-1:0]         num_ff, num_in;
   logic [QuotW-1:0]         quot_ff, quot_in;
   logic signed [NormW-1:0]  out_x_ff, out_y_ff, out_z_ff;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic signed [MulW-1:0]   mul_a, mul_b;
   logic signed [ProdW-1:0]  prod;
   logic signed [CrossW-1:0] prod_c;
   logic [Mag2W-1:0]         su_a, su_b, su_diff;
   logic                     su_ge;

   logic [CompW-1:0]         sq_comp, sel_comp;
   logic [1:0]               sq_part, acc_part;
   logic signed [CrossW-1:0] cross_sel;
   logic                     cross_neg;
   logic [CrossW-1:0]        cross_abs;
   logic signed [MulW-1:0]   lo_op, hi_op;
   logic [MagW-1:0]          mag;
   logic [MagW-1:0]          abs32;
   logic [CoordW+QuotW-1:0]  scaled;
   logic [MagW:0]            trial;
   logic [QuotW-1:0]         q_pick;
   logic [NormW-1:0]         q_ext;
   logic signed [NormW-1:0]  q_signed;

   tun_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .ctl   (ctl)
   );

   tun_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

   tun_cmpsub u_cmpsub (
      .a    (su_a),
      .b    (su_b),
      .diff (su_diff),
      .ge   (su_ge)
   );

   assign req_stall = ctl.busy;
   assign mag       = r_ff[MagW-1:0];
   assign prod_c    = prod[CrossW-1:0];

   always_comb begin
      sts.req_fire  = req_valid && !req_stall;
      sts.mag2_zero = (mag2_ff == '0);
      sts.clamp     = su_ge;
      sts.out_free  = !rsp_valid_ff || !rsp_stall;
   end

   // component and partial product of each square step
   always_comb begin
      case (ctl.step)
         5'd0, 5'd1, 5'd2: sq_comp = 2'd0;
         5'd3, 5'd4, 5'd5: sq_comp = 2'd1;
         default:          sq_comp = 2'd2;
      endcase
      case (ctl.step)
         5'd0, 5'd3, 5'd6: sq_part = 2'd0;
         5'd1, 5'd4, 5'd7: sq_part = 2'd1;
         default:          sq_part = 2'd2;
      endcase
      case (ctl.step)
         5'd1, 5'd4, 5'd7: acc_part = 2'd0;
         5'd2, 5'd5, 5'd8: acc_part = 2'd1;
         default:          acc_part = 2'd2;
      endcase
   end

   always_comb begin
      sel_comp  = (ctl.state == ST_SQUARE) ? sq_comp : ctl.comp;
      cross_sel = cross_ff[sel_comp];
      cross_neg = cross_sel[CrossW-1];
      cross_abs = cross_neg ? CrossW'(-cross_sel) : CrossW'(cross_sel);
      lo_op     = MulW'({1'b0, cross_abs[LoW-1:0]});
      hi_op     = MulW'({2'b00, cross_abs[CrossW-1:LoW]});
      abs32     = cross_abs[MagW-1:0];
      scaled    = {abs32, QuotW'(0)} - {QuotW'(0), abs32};
      trial     = {rem_ff, num_ff[QuotW-1]};
   end

   // multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (ctl.state == ST_CROSS) begin
         case (ctl.step)
            5'd0: begin mul_a = MulW'(edge_ff[1]); mul_b = MulW'(edge_ff[5]); end
            5'd1: begin mul_a = MulW'(edge_ff[2]); mul_b = MulW'(edge_ff[4]); end
            5'd2: begin mul_a = MulW'(edge_ff[2]); mul_b = MulW'(edge_ff[3]); end
            5'd3: begin mul_a = MulW'(edge_ff[0]); mul_b = MulW'(edge_ff[5]); end
            5'd4: begin mul_a = MulW'(edge_ff[0]); mul_b = MulW'(edge_ff[4]); end
            5'd5: begin mul_a = MulW'(edge_ff[1]); mul_b = MulW'(edge_ff[3]); end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end else if (ctl.state == ST_SQUARE) begin
         case (sq_part)
            2'd0:    begin mul_a = lo_op; mul_b = lo_op; end
            2'd1:    begin mul_a = hi_op; mul_b = lo_op; end
            default: begin mul_a = hi_op; mul_b = hi_op; end
         endcase
      end
   end

   // shared compare-subtract operands
   always_comb begin
      case (ctl.state)
         ST_ROOT: begin
            su_a = v_ff;
            su_b = r_ff | bit_ff;
         end
         ST_DIV_INIT: begin
            su_a = Mag2W'(cross_abs);
            su_b = Mag2W'(mag);
         end
         ST_DIV_STEP: begin
            su_a = Mag2W'(trial);
            su_b = Mag2W'(mag);
         end
         default: begin
            su_a = '0;
            su_b = '0;
         end
      endcase
   end

   // signed quotient of the current component
   always_comb begin
      q_pick   = (ctl.state == ST_DIV_INIT) ? NormOne : {quot_ff[QuotW-2:0], su_ge};
      q_ext    = {1'b0, q_pick};
      q_signed = cross_neg ? $signed(NormW'(0) - q_ext) : $signed(q_ext);
   end

   always_comb begin
      edge_in  = edge_ff;
      cross_in = cross_ff;
      res_in   = res_ff;
      mag2_in  = mag2_ff;
      v_in     = v_ff;
      r_in     = r_ff;
      bit_in   = bit_ff;
      rem_in   = rem_ff;
      num_in   = num_ff;
      quot_in  = quot_ff;
      case (ctl.state)
         ST_IDLE: begin
            if (sts.req_fire) begin
               edge_in[0] = edge_diff(req_vert_b_x, req_vert_a_x);
               edge_in[1] = edge_diff(req_vert_b_y, req_vert_a_y);
               edge_in[2] = edge_diff(req_vert_b_z, req_vert_a_z);
               edge_in[3] = edge_diff(req_vert_c_x, req_vert_a_x);
               edge_in[4] = edge_diff(req_vert_c_y, req_vert_a_y);
               edge_in[5] = edge_diff(req_vert_c_z, req_vert_a_z);
            end
         end
         ST_CROSS: begin
            mag2_in = '0;
            case (ctl.step)
               5'd1: cross_in[0] = prod_c;
               5'd2: cross_in[0] = cross_ff[0] - prod_c;
               5'd3: cross_in[1] = prod_c;
               5'd4: cross_in[1] = cross_ff[1] - prod_c;
               5'd5: cross_in[2] = prod_c;
               5'd6: cross_in[2] = cross_ff[2] - prod_c;
               default: cross_in = cross_ff;
            endcase
         end
         ST_SQUARE: begin
            if (ctl.step != 5'd0) begin
               case (acc_part)
                  2'd0:    mag2_in = mag2_ff + {10'b0, prod[53:0]};
                  2'd1:    mag2_in = mag2_ff + {prod[35:0], 28'b0};
                  default: mag2_in = mag2_ff + {prod[9:0], 54'b0};
               endcase
            end
         end
         ST_CHECK: begin
            if (sts.mag2_zero) begin
               res_in[0] = '0;
               res_in[1] = $signed({1'b0, NormOne});
               res_in[2] = '0;
            end else begin
               v_in   = mag2_ff;
               r_in   = '0;
               bit_in = Mag2W'(1) << RootTopBit;
            end
         end
         ST_ROOT: begin
            if (su_ge) begin
               v_in = su_diff;
               r_in = (r_ff >> 1) + bit_ff;
            end else begin
               r_in = r_ff >> 1;
            end
            bit_in = bit_ff >> 2;
         end
         ST_DIV_INIT: begin
            if (su_ge) begin
               res_in[ctl.comp] = q_signed;
            end else begin
               rem_in  = scaled[CoordW+QuotW-1:QuotW];
               num_in  = scaled[QuotW-1:0];
               quot_in = '0;
            end
         end
         ST_DIV_STEP: begin
            rem_in  = su_ge ? su_diff[MagW-1:0] : trial[MagW-1:0];
            num_in  = {num_ff[QuotW-2:0], 1'b0};
            quot_in = {quot_ff[QuotW-2:0], su_ge};
            if (ctl.step == DivLast) res_in[ctl.comp] = q_signed;
         end
         default: begin
            mag2_in = mag2_ff;
         end
      endcase
   end

   assign rsp_valid_in = ctl.load_out || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      edge_ff  <= edge_in;
      cross_ff <= cross_in;
      res_ff   <= res_in;
      mag2_ff  <= mag2_in;
      v_ff     <= v_in;
      r_ff     <= r_in;
      bit_ff   <= bit_in;
      rem_ff   <= rem_in;
      num_ff   <= num_in;
      quot_ff  <= quot_in;
      if (ctl.load_out) begin
         out_x_ff <= res_ff[0];
         out_y_ff <= res_ff[1];
         out_z_ff <= res_ff[2];
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_norm_x = out_x_ff;
   assign rsp_norm_y = out_y_ff;
   assign rsp_norm_z = out_z_ff;

`ifndef SYNTHESIS
   a_valid_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(ctl.state == ST_FINISH))
      else $error("result valid without finished item");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("block ready right after accepting an item");

   a_rem_below_mag: assert property (@(posedge clock) disable iff (reset)
      (ctl.state == ST_DIV_STEP) |-> (rem_ff < mag))
      else $error("divide remainder not below magnitude");

   a_norm_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_norm_x != -16'sd32768 && rsp_norm_y != -16'sd32768
                     && rsp_norm_z != -16'sd32768))
      else $error("normal component out of range");
`endif

endmodule

// ===== src/tun_mul.sv =====
// shared signed multiplier with registered product
module tun_mul (
   input  logic                             clock,
   input  logic signed [tun_pkg::MulW-1:0]  a,
   input  logic signed [tun_pkg::MulW-1:0]  b,
   output logic signed [tun_pkg::ProdW-1:0] prod
);
   import tun_pkg::*;

   logic signed [ProdW-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= a * b;
   end

   assign prod = prod_ff;

endmodule

// ===== src/tun_cmpsub.sv =====
// shared 64-bit compare and subtract unit for root and divide steps
module tun_cmpsub (
   input  logic [tun_pkg::Mag2W-1:0] a,
   input  logic [tun_pkg::Mag2W-1:0] b,
   output logic [tun_pkg::Mag2W-1:0] diff,
   output logic                      ge
);
   import tun_pkg::*;

   logic [Mag2W:0] wide;

   assign wide = {1'b0, a} - {1'b0, b};
   assign diff = wide[Mag2W-1:0];
   assign ge   = ~wide[Mag2W];

endmodule

// ===== src/tun_ctrl.sv =====
// sequencer: state, step and component counters
module tun_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  tun_pkg::sts_type sts,
   output tun_pkg::ctl_type ctl
);
   import tun_pkg::*;

   state_type        state_ff, state_in;
   logic [StepW-1:0] step_ff, step_in;
   logic [CompW-1:0] comp_ff, comp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         comp_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         comp_ff  <= comp_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff + 5'd1;
      comp_in  = comp_ff;
      case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            comp_in = '0;
            if (sts.req_fire) state_in = ST_CROSS;
         end
         ST_CROSS: begin
            if (step_ff == CrossLast) begin
               state_in = ST_SQUARE;
               step_in  = '0;
            end
         end
         ST_SQUARE: begin
            if (step_ff == SquareLast) begin
               state_in = ST_CHECK;
               step_in  = '0;
            end
         end
         ST_CHECK: begin
            step_in  = '0;
            state_in = sts.mag2_zero ? ST_FINISH : ST_ROOT;
         end
         ST_ROOT: begin
            if (step_ff == RootLast) begin
               state_in = ST_DIV_INIT;
               step_in  = '0;
               comp_in  = '0;
            end
         end
         ST_DIV_INIT: begin
            step_in = '0;
            if (sts.clamp) begin
               if (comp_ff == CompLast) state_in = ST_FINISH;
               else comp_in = comp_ff + 2'd1;
            end else begin
               state_in = ST_DIV_STEP;
            end
         end
         ST_DIV_STEP: begin
            if (step_ff == DivLast) begin
               step_in = '0;
               if (comp_ff == CompLast) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_DIV_INIT;
                  comp_in  = comp_ff + 2'd1;
               end
            end
         end
         ST_FINISH: begin
            step_in = '0;
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
            step_in  = '0;
         end
      endcase
   end

   always_comb begin
      ctl.state    = state_ff;
      ctl.step     = step_ff;
      ctl.comp     = comp_ff;
      ctl.busy     = (state_ff != ST_IDLE);
      ctl.load_out = (state_ff == ST_FINISH) && sts.out_free;
   end

endmodule

// ===== tb/triangle_unit_normal_q15_tb.sv =====
// testbench for the triangle unit normal block: directed and random triangles against a predictor
`timescale 1ns / 1ps

module triangle_unit_normal_q15_tb;

   import tun_pkg::*;

   localparam int          EdgeShr     = 6;
   localparam logic [63:0] UnitScale   = 64'd32767;
   localparam int          CycleLimit  = 2000000;
   localparam int          DrainCycles = 300;

   typedef struct packed {
      logic [CoordW-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
   } triangle_type;

   typedef struct packed {
      logic signed [NormW-1:0] x, y, z;
   } normal_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic signed [CoordW-1:0] req_vert_a_x, req_vert_a_y, req_vert_a_z;
   logic signed [CoordW-1:0] req_vert_b_x, req_vert_b_y, req_vert_b_z;
   logic signed [CoordW-1:0] req_vert_c_x, req_vert_c_y, req_vert_c_z;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [NormW-1:0] rsp_norm_x, rsp_norm_y, rsp_norm_z;

   normal_type pending_normals[$];
   int         error_count;
   int         cycle_count;
   bit         idle_on;
   int         stall_left;

   triangle_unit_normal_q15 dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_vert_a_x (req_vert_a_x),
      .req_vert_a_y (req_vert_a_y),
      .req_vert_a_z (req_vert_a_z),
      .req_vert_b_x (req_vert_b_x),
      .req_vert_b_y (req_vert_b_y),
      .req_vert_b_z (req_vert_b_z),
      .req_vert_c_x (req_vert_c_x),
      .req_vert_c_y (req_vert_c_y),
      .req_vert_c_z (req_vert_c_z),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_norm_x   (rsp_norm_x),
      .rsp_norm_y   (rsp_norm_y),
      .rsp_norm_z   (rsp_norm_z)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic longint edge_step(input logic [CoordW-1:0] p, input logic [CoordW-1:0] q);
      logic [CoordW-1:0] d;
      begin
         d = p - q;
         return longint'($signed(d)) >>> EdgeShr;
      end
   endfunction

   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] rem, root, b;
      begin
         rem  = v;
         root = 64'd0;
         b    = 64'd1 << 62;
         while (b > rem) b = b >> 2;
         while (b != 0) begin
            if (rem >= root + b) begin
               rem  = rem - (root + b);
               root = (root >> 1) + b;
            end else begin
               root = root >> 1;
            end
            b = b >> 2;
         end
         return root;
      end
   endfunction

   function automatic logic [NormW-1:0] scale_q15(input longint c, input logic [63:0] mag);
      logic [63:0] a, q;
      begin
         a = (c < 0) ? -c : c;
         if (a >= mag) begin
            q = UnitScale;
         end else begin
            q = (a * UnitScale) / mag;
         end
         if (c < 0) q = -q;
         return q[NormW-1:0];
      end
   endfunction

   function automatic normal_type unit_normal(input triangle_type t);
      longint      ux, uy, uz, vx, vy, vz, nx, ny, nz;
      logic [63:0] len2, len;
      normal_type  n;
      begin
         ux = edge_step(t.bx, t.ax);
         uy = edge_step(t.by, t.ay);
         uz = edge_step(t.bz, t.az);
         vx = edge_step(t.cx, t.ax);
         vy = edge_step(t.cy, t.ay);
         vz = edge_step(t.cz, t.az);
         nx = uy * vz - uz * vy;
         ny = uz * vx - ux * vz;
         nz = ux * vy - uy * vx;
         // squared length wraps modulo 2^64
         len2 = nx * nx + ny * ny + nz * nz;
         if (len2 == 0) begin
            n.x = '0;
            n.y = UnitScale[NormW-1:0];
            n.z = '0;
         end else begin
            len = isqrt64(len2);
            n.x = scale_q15(nx, len);
            n.y = scale_q15(ny, len);
            n.z = scale_q15(nz, len);
         end
         return n;
      end
   endfunction

   function automatic logic [CoordW-1:0] rand_offset(input int k);
      logic [CoordW-1:0] r;
      begin
         r = $urandom & ((32'd1 << k) - 32'd1);
         if ($urandom_range(0, 1) == 1) r = -r;
         return r;
      end
   endfunction

   task automatic send_triangle(input logic [CoordW-1:0] ax, ay, az, bx, by, bz, cx, cy, cz);
      triangle_type t;
      int           gap;
      begin
         t   = '{ax, ay, az, bx, by, bz, cx, cy, cz};
         gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
         @(negedge clock);
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_vert_a_x = t.ax;
         req_vert_a_y = t.ay;
         req_vert_a_z = t.az;
         req_vert_b_x = t.bx;
         req_vert_b_y = t.by;
         req_vert_b_z = t.bz;
         req_vert_c_x = t.cx;
         req_vert_c_y = t.cy;
         req_vert_c_z = t.cz;
         req_valid    = 1'b1;
         do @(posedge clock); while (req_stall);
         pending_normals.push_back(unit_normal(t));
      end
   endtask

   task automatic send_random_triangle();
      logic [CoordW-1:0] a [3];
      logic [CoordW-1:0] du [3];
      logic [CoordW-1:0] dv [3];
      int k, m, flat;
      begin
         for (int i = 0; i < 3; i++) begin
            a[i]  = $urandom;
            du[i] = $urandom;
            dv[i] = $urandom;
         end
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               k = $urandom_range(6, 24);
               for (int i = 0; i < 3; i++) begin
                  du[i] = rand_offset(k);
                  dv[i] = rand_offset(k);
               end
            end
            4, 5: begin
            end
            6: begin
               // collinear edges
               k = $urandom_range(0, 18);
               m = $urandom_range(0, 6) - 3;
               for (int i = 0; i < 3; i++) begin
                  du[i] = rand_offset(k) << EdgeShr;
                  dv[i] = du[i] * m;
               end
            end
            7: begin
               // flat in one axis
               k    = $urandom_range(6, 24);
               flat = $urandom_range(0, 2);
               for (int i = 0; i < 3; i++) begin
                  du[i] = rand_offset(k);
                  dv[i] = rand_offset(k);
               end
               du[flat] = '0;
               dv[flat] = '0;
            end
            8: begin
               for (int i = 0; i < 3; i++) begin
                  du[i] = rand_offset($urandom_range(0, 7));
                  dv[i] = rand_offset($urandom_range(0, 7));
               end
            end
            default: begin
               for (int i = 0; i < 3; i++) begin
                  du[i] = rand_offset($urandom_range(25, 31));
                  dv[i] = rand_offset($urandom_range(25, 31));
               end
            end
         endcase
         send_triangle(a[0], a[1], a[2],
                       a[0] + du[0], a[1] + du[1], a[2] + du[2],
                       a[0] + dv[0], a[1] + dv[1], a[2] + dv[2]);
      end
   endtask

   task automatic test_degenerate();
      begin
         send_triangle(0, 0, 0, 0, 0, 0, 0, 0, 0);
         send_triangle('1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1,
                       '1 >> 1, '1 >> 1, '1 >> 1);
         send_triangle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
         send_triangle(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                       32'h0005_0000, 32'hFFF0_0000, 32'h0000_1000,
                       32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
         send_triangle(32'h1000_0000, 32'hF000_0000, 32'h0000_0040,
                       32'h1001_0000, 32'hF000_0040, 32'hFFFF_FFC0,
                       32'h1002_0000, 32'hF000_0080, 32'hFFFF_FF40);
         // edges vanish under the shift
         send_triangle(0, 0, 0, 63, 0, 0, 0, 63, 0);
      end
   endtask

   task automatic test_axis_aligned();
      begin
         send_triangle(0, 0, 0, 32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0);
         send_triangle(0, 0, 0, 0, 32'h0001_0000, 0, 32'h0001_0000, 0, 0);
         send_triangle(0, 0, 0, 0, 32'h0001_0000, 0, 0, 0, 32'h0003_0000);
         send_triangle(0, 0, 0, 0, 0, 32'h0002_0000, 32'h0001_0000, 0, 0);
         send_triangle(32'h0000_8000, 32'h0004_0000, 32'hFFFF_0000,
                       32'h0003_8000, 32'h0005_0000, 32'hFFFF_0000,
                       32'hFFFE_8000, 32'h0009_0000, 32'h0002_0000);
         // edges of minus one after the shift
         send_triangle(0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 32'hFFFF_FFFF, 0);
      end
   endtask

   task automatic test_extremes();
      begin
         send_triangle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0);
         send_triangle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       32'h7FFF_FFFF, 0, 32'h8000_0000);
         send_triangle(32'h8000_0000, 0, 32'h7FFF_FFFF,
                       32'h7FFF_FFFF, 32'h8000_0000, 0,
                       0, 32'h7FFF_FFFF, 32'h8000_0000);
         send_triangle(0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA);
         send_triangle(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                       32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                       32'hFFFF_FFFF, 0, 32'hFFFF_FFFF);
      end
   endtask

   task automatic test_wrapped_length();
      begin
         // squared length wraps to exactly zero
         send_triangle(0, 0, 0, 32'h0040_0000, 0, 0, 0, 32'h0040_0000, 0);
         // wrapped length smaller than a component, clamps
         send_triangle(0, 0, 0, 32'h0040_0000, 0, 0, 0, 32'h0040_0040, 0);
         send_triangle(0, 0, 0, 32'h7FFF_FFC0, 0, 0, 0, 32'h7FFF_FFC0, 0);
         send_triangle(0, 0, 0, 32'h8000_0000, 32'h1234_5678, 0,
                       32'h0ABC_DEF0, 32'h8000_0000, 32'h7FFF_FFFF);
         send_triangle(32'h1000_0000, 32'h2000_0000, 32'h3000_0000,
                       32'h9000_0000, 32'hA000_0040, 32'h3000_0000,
                       32'h1000_0000, 32'hA000_0000, 32'hB000_0000);
      end
   endtask

   task automatic test_random(input int count);
      begin
         repeat (count) send_random_triangle();
      end
   endtask

   task automatic test_full_rate(input int count);
      begin
         idle_on = 1'b0;
         repeat (count) send_random_triangle();
      end
   endtask

   // result side stall bursts
   initial begin
      rsp_stall  = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (idle_on && stall_left == 0 && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 18);
         end
         rsp_stall = idle_on && stall_left != 0;
         if (stall_left != 0) stall_left--;
      end
   end

   always @(posedge clock) begin : check_results
      normal_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_normals.size() == 0) begin
            error_count++;
            $error("normal with no triangle outstanding: %0d %0d %0d",
                   rsp_norm_x, rsp_norm_y, rsp_norm_z);
         end else begin
            want = pending_normals.pop_front();
            if (rsp_norm_x !== want.x) begin
               error_count++;
               $error("norm_x: expected %0d, got %0d", want.x, rsp_norm_x);
            end
            if (rsp_norm_y !== want.y) begin
               error_count++;
               $error("norm_y: expected %0d, got %0d", want.y, rsp_norm_y);
            end
            if (rsp_norm_z !== want.z) begin
               error_count++;
               $error("norm_z: expected %0d, got %0d", want.z, rsp_norm_z);
            end
         end
      end
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("triangle_unit_normal_q15_tb failed");
      $finish;
   end

   initial begin
      error_count  = 0;
      idle_on      = 1'b1;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_vert_a_x = '0;
      req_vert_a_y = '0;
      req_vert_a_z = '0;
      req_vert_b_x = '0;
      req_vert_b_y = '0;
      req_vert_b_z = '0;
      req_vert_c_x = '0;
      req_vert_c_y = '0;
      req_vert_c_z = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_degenerate();
      test_axis_aligned();
      test_extremes();
      test_wrapped_length();
      test_random(1300);
      test_full_rate(250);

      @(negedge clock);
      req_valid = 1'b0;
      while (pending_normals.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0) begin
         $display("triangle_unit_normal_q15_tb passed");
      end else begin
         $display("triangle_unit_normal_q15_tb failed");
      end
      $finish;
   end

endmodule
